>>> rtl/itda_pkg.sv
// Shared types, constants and the double-dabble step for the integer to decimal ASCII unit.
// Used by every module of the block. Depends on nothing.
package itda_pkg;

  localparam int VALUE_W          = 32;
  localparam int CHAR_W           = 8;
  localparam int DIGIT_COUNT      = 10;
  localparam int BCD_W            = 4 * DIGIT_COUNT;
  localparam int BITS_PER_STEP    = 4;
  localparam int CONV_STEPS       = VALUE_W / BITS_PER_STEP;
  localparam int ITDA_QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [3:0]        DIGIT_MAX   = 4'd9;
  localparam logic [3:0]        DABBLE_MIN  = 4'd5;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } itda_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } itda_q_status_t;

  // One shift-and-add-3 step: adjust every BCD digit, then shift in one binary bit.
  function automatic logic [BCD_W-1:0] bcd_step(input logic [BCD_W-1:0] bcd, input logic b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      if (bcd[4*d +: 4] >= DABBLE_MIN) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

endpackage

>>> rtl/itda_front.sv
// Front end: accepts input items and classifies them into sign and unsigned magnitude.
// Depends on itda_pkg; feeds the item queue.
module itda_front import itda_pkg::*; (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,   // bits 31:0 value
  input  itda_q_status_t     q_status,
  output logic               push,
  output itda_item_t         push_item
);

  logic neg;

  assign neg      = s_tdata[VALUE_W-1];
  assign s_tready = !q_status.full;
  assign push     = s_tvalid && !q_status.full;

  // The magnitude is unsigned, so the most negative value maps onto 2^31.
  assign push_item.neg = neg;
  assign push_item.mag = neg ? (VALUE_W'(0) - s_tdata) : s_tdata;

endmodule

>>> rtl/itda_queue.sv
// Short FIFO of classified items between the front end and the converter.
// Depends on itda_pkg.
module itda_queue import itda_pkg::*; #(
  parameter int DEPTH = ITDA_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  itda_item_t     push_item,
  input  logic           pop,
  output itda_item_t     pop_item,
  output itda_q_status_t status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  itda_item_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == DEPTH_CNT);
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/itda_back.sv
// Back end: double-dabble binary to BCD converter followed by a character emitter.
// Depends on itda_pkg; takes items from the queue and drives the output stream.
module itda_back import itda_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  itda_q_status_t    q_status,
  input  itda_item_t        pop_item,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [CHAR_W-1:0] m_tdata,   // bits 7:0 character
  output logic              m_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int STEP_W = $clog2(CONV_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CONV_STEPS - 1);

  // Converter.
  logic [1:0]         state;
  logic [STEP_W-1:0]  step;
  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic               conv_neg;
  logic [VALUE_W-1:0] bin_next;
  logic [BCD_W-1:0]   bcd_next;

  // Emitter; its registers are the output stage.
  logic [3:0]         digits [DIGIT_COUNT];
  logic [3:0]         pos;
  logic               sign_pending;
  logic               active;
  logic               emit_ready;
  logic               load;
  logic [3:0]         top_digit;
  logic [3:0]         cur_digit;
  logic               out_accept;

  always_comb begin
    bin_next = bin;
    bcd_next = bcd;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      bcd_next = bcd_step(bcd_next, bin_next[VALUE_W-1]);
      bin_next = {bin_next[VALUE_W-2:0], 1'b0};
    end
  end

  assign pop = (state == ST_IDLE) && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          step <= step + STEP_W'(1);
          if (step == LAST_STEP) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (emit_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bin      <= pop_item.mag;
      bcd      <= '0;
      conv_neg <= pop_item.neg;
    end else if (state == ST_RUN) begin
      bin <= bin_next;
      bcd <= bcd_next;
    end
  end

  // Highest nonzero digit; zero leaves the units digit as the only one.
  always_comb begin
    top_digit = '0;
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        top_digit = 4'(d);
      end
    end
  end

  assign out_accept = m_tvalid && m_tready;
  assign m_tvalid   = active;
  assign cur_digit  = digits[pos];
  assign m_tlast    = !sign_pending && (pos == 4'd0);
  assign m_tdata    = sign_pending ? ASCII_MINUS : (ASCII_ZERO + {4'b0000, cur_digit});
  // The emitter takes the next number in the cycle its final character leaves.
  assign emit_ready = !active || (out_accept && m_tlast);
  assign load       = (state == ST_DONE) && emit_ready;

  always_ff @(posedge clk) begin
    if (load) begin
      for (int d = 0; d < DIGIT_COUNT; d++) begin
        digits[d] <= bcd[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      sign_pending <= 1'b0;
      pos          <= '0;
    end else if (load) begin
      active       <= 1'b1;
      sign_pending <= conv_neg;
      pos          <= top_digit;
    end else if (out_accept) begin
      if (sign_pending) begin
        sign_pending <= 1'b0;
      end else if (pos == 4'd0) begin
        active <= 1'b0;
      end else begin
        pos <= pos - 4'd1;
      end
    end
  end

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata == ASCII_MINUS) |-> !m_tlast)
    else $error("minus sign marked as last character");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !sign_pending |-> (cur_digit <= DIGIT_MAX))
    else $error("emitted digit is not a decimal digit");

  a_conv_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && (step == LAST_STEP) |=> (state == ST_DONE))
    else $error("conversion did not finish after its last step");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && !emit_ready |=> (state == ST_DONE))
    else $error("converted number dropped before the emitter took it");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pos < 4'(DIGIT_COUNT)))
    else $error("digit position out of range");

endmodule

>>> rtl/int_to_decimal_ascii_unit.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on itda_pkg, itda_front, itda_queue and itda_back.
//
//   Channel  Direction  Payload                      Items per number
//   s_*      in         tdata[31:0] value            1
//   m_*      out        tdata[7:0] character, tlast  1 to 11
//
// A number enters the queue when it is accepted and leaves it once the converter is idle. It
// is converted in CONV_STEPS steps of the double-dabble loop, four bits a cycle, and is held
// until the emitter can take it. The emitter sends one character per cycle while m_tready is
// high, the sign first, while the converter works on the next number; the sustained rate is
// set by the converter loop or by the character count, whichever is larger.
// Reset is synchronous and clears the queue, converter and emitter; stalls on m_tready hold the
// current character and back up through the queue to s_tready.
module int_to_decimal_ascii_unit import itda_pkg::*; #(
  parameter int QUEUE_DEPTH = ITDA_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,   // bits 31:0 value
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [CHAR_W-1:0]  m_tdata,   // bits 7:0 character
  output logic               m_tlast
);

  itda_q_status_t q_status;
  itda_item_t     push_item;
  itda_item_t     pop_item;
  logic           push;
  logic           pop;

  itda_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  itda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  itda_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop_item (pop_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
